// ----- rtl/rv64mwa_pkg.sv -----
// rv64mwa_pkg: shared types, codes and helpers of the rv64 memory with atomics unit
// no dependencies; imported by the front, the back and the top level
package rv64mwa_pkg;

    // ram geometry
    localparam int unsigned MEM_BYTES  = 65536;
    localparam int unsigned WORD_COUNT = (MEM_BYTES + 7) / 8;
    localparam int unsigned IDX_W      = $clog2(WORD_COUNT);
    localparam logic [63:0] MEM_BYTES_64 = 64'(MEM_BYTES);

    // configuration registers
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned REG_SEL_BIT = 3;
    localparam logic        REG_RAM_BASE    = 1'b0;
    localparam logic        REG_DEVICE_BASE = 1'b1;
    localparam logic [63:0] RAM_BASE_RST    = 64'h0000_0000_8000_0000;
    localparam logic [63:0] DEVICE_BASE_RST = 64'h0000_c000_0000_0000;

    // queue depths
    localparam int unsigned CQ_DEPTH = 2;
    localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int unsigned RQ_DEPTH = 2;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // access kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_AMO   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAULT    = 2'd1;
    localparam logic [1:0] ST_MISALIGN = 2'd2;
    localparam logic [1:0] ST_DEVICE   = 2'd3;

    // atomic operation codes (funct7 bits 6..2)
    localparam logic [4:0] AMO_ADD  = 5'h00;
    localparam logic [4:0] AMO_SWAP = 5'h01;
    localparam logic [4:0] AMO_LR   = 5'h02;
    localparam logic [4:0] AMO_SC   = 5'h03;
    localparam logic [4:0] AMO_XOR  = 5'h04;
    localparam logic [4:0] AMO_OR   = 5'h08;
    localparam logic [4:0] AMO_AND  = 5'h0c;
    localparam logic [4:0] AMO_MIN  = 5'h10;
    localparam logic [4:0] AMO_MAX  = 5'h14;
    localparam logic [4:0] AMO_MINU = 5'h18;
    localparam logic [4:0] AMO_MAXU = 5'h1c;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] addr;
        logic [3:0]  size_bytes;
        logic [6:0]  amo_funct7;
        logic [63:0] wdata;
    } in_t;

    typedef struct packed {
        logic [63:0] rdata;
        logic [1:0]  status;
    } out_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]       kind;
        logic [4:0]       op;
        logic [63:0]      addr;
        logic [IDX_W-1:0] idx;
        logic [2:0]       boff;
        logic [3:0]       size;
        logic [63:0]      wdata;
        logic [1:0]       status;
    } cmd_t;

    function automatic logic [63:0] size_mask(input logic [3:0] size);
        logic [63:0] m;
        case (size)
            4'd1:    m = 64'h0000_0000_0000_00ff;
            4'd2:    m = 64'h0000_0000_0000_ffff;
            4'd4:    m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

// ----- rtl/rv64_memory_with_atomics_unit.sv -----
// rv64_memory_with_atomics_unit: top level with the configuration registers
// depends on rv64mwa_pkg, rv64mwa_front and rv64mwa_back
//
// usage
//   access words enter through push/full: a word is taken at a clock edge with
//   push high and full low. each word gives exactly one result word on rsp,
//   shown while empty is low and taken at an edge with pop high.
//   ram_base (byte 0) and device_base (byte 8) sit on a 64-bit apb-style port;
//   reads return them; write them only while the unit is idle (not enforced).
// ram access and pacing
//   the single ram port first reads the addressed 64-bit word when a word is
//   taken; in the exec state of the next cycle the result is queued and the
//   merged word is written back. every kind of access, faulting ones included,
//   passes through this pair, though only writes and atomics other than lr and
//   a failed sc write; the back part takes no new word before it is done.
// reset and stalls
//   reset empties both queues, clears the reservation and loads the base
//   registers with their defaults; ram contents stay undefined until written.
//   the result queue holds two words; when it is full the back part waits,
//   the two-entry command queue fills behind it and full rises.
module rv64_memory_with_atomics_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // access words
    input  logic                              push,
    output logic                              full,
    input  rv64mwa_pkg::in_t                  req,
    // result words
    output logic                              empty,
    input  logic                              pop,
    output rv64mwa_pkg::out_t                 rsp,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rv64mwa_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready
);
    import rv64mwa_pkg::*;

    logic [63:0] ram_base_reg;
    logic [63:0] device_base_reg;
    logic        cfg_wr;
    logic        reg_sel;
    logic        cmd_valid;
    logic        cmd_take;
    cmd_t        cmd;

    // register file: one 64-bit register per 8-byte slot
    assign pready  = 1'b1;
    assign reg_sel = paddr[REG_SEL_BIT];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == REG_DEVICE_BASE) ? device_base_reg : ram_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_base_reg    <= RAM_BASE_RST;
            device_base_reg <= DEVICE_BASE_RST;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_RAM_BASE)
                ram_base_reg <= pwdata;
            else
                device_base_reg <= pwdata;
        end
    end

    // front: classify and queue
    rv64mwa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req         (req),
        .ram_base    (ram_base_reg),
        .device_base (device_base_reg),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd)
    );

    // back: ram access, atomics, result queue
    rv64mwa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/rv64mwa_front.sv -----
// rv64mwa_front: accepts access words, checks device region, range and alignment,
// and queues the classified words for the back; depends on rv64mwa_pkg
module rv64mwa_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  rv64mwa_pkg::in_t   req,
    input  logic [63:0]        ram_base,
    input  logic [63:0]        device_base,
    output logic               cmd_valid,
    input  logic               cmd_take,
    output rv64mwa_pkg::cmd_t  cmd
);
    import rv64mwa_pkg::*;

    logic [63:0]         off;
    logic [63:0]         limit;
    logic                out_range;
    logic                size_ok;
    logic                aligned;
    logic                amo_size_ok;
    logic [1:0]          status;
    cmd_t                cls;
    logic                push_ok;

    cmd_t                q_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;

    // range: offset from base must leave room for the whole access
    assign off       = req.addr - ram_base;
    assign limit     = MEM_BYTES_64 - 64'(req.size_bytes);
    assign out_range = (req.addr < ram_base) || (off > limit);
    assign amo_size_ok = (req.size_bytes == 4'd4) || (req.size_bytes == 4'd8);

    always_comb
    begin
        size_ok = 1'b0;
        aligned = 1'b0;
        case (req.size_bytes)
            4'd1:
            begin
                size_ok = 1'b1;
                aligned = 1'b1;
            end
            4'd2:
            begin
                size_ok = 1'b1;
                aligned = ~req.addr[0];
            end
            4'd4:
            begin
                size_ok = 1'b1;
                aligned = (req.addr[1:0] == 2'b00);
            end
            4'd8:
            begin
                size_ok = 1'b1;
                aligned = (req.addr[2:0] == 3'b000);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        status = ST_FAULT;
        unique case (req.kind) inside
            KIND_READ, KIND_WRITE:
            begin
                if (req.addr >= device_base)
                    status = ST_DEVICE;
                else if (out_range)
                    status = ST_FAULT;
                else if (!(size_ok && aligned))
                    status = ST_MISALIGN;
                else
                    status = ST_OK;
            end
            KIND_AMO:
            begin
                // atomics skip the device check
                if (out_range)
                    status = ST_FAULT;
                else if (!(amo_size_ok && aligned))
                    status = ST_MISALIGN;
                else
                    status = ST_OK;
            end
            default: status = ST_FAULT;
        endcase
    end

    always_comb
    begin
        cls.kind   = req.kind;
        cls.op     = req.amo_funct7[6:2];
        cls.addr   = req.addr;
        cls.idx    = off[IDX_W+2:3];
        cls.boff   = off[2:0];
        cls.size   = req.size_bytes;
        cls.wdata  = req.wdata;
        cls.status = status;
    end

    // command queue
    assign full      = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign push_ok   = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (cmd_take)
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push_ok && !cmd_take)
            cnt_next = cnt_reg + 1'b1;
        else if (!push_ok && cmd_take)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ----- rtl/rv64mwa_back.sv -----
// rv64mwa_back: ram, reservation and atomic alu; reads a word, then, where the access
// calls for it, modifies and writes it back, and queues the result word; depends on rv64mwa_pkg
module rv64mwa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  rv64mwa_pkg::cmd_t  cmd,
    output logic               empty,
    input  logic               pop,
    output rv64mwa_pkg::out_t  rsp
);
    import rv64mwa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cur_reg;
    logic [63:0]         rd_word_reg;
    logic [63:0]         mem_reg [WORD_COUNT];
    logic [63:0]         resv_addr_reg;
    logic                resv_valid_reg;

    logic                exec;
    logic [5:0]          sh;
    logic [63:0]         m;
    logic [63:0]         old;
    logic                is_word;
    logic [63:0]         a;
    logic [63:0]         b;
    logic                lt_s;
    logic                lt_u;
    logic [63:0]         alu;
    logic                resv_hit;
    logic                mem_we;
    logic [63:0]         store_data;
    logic [63:0]         mem_wdata;
    logic [63:0]         rdata;
    logic                resv_set;
    logic                resv_clr;
    out_t                res;

    out_t                rq_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] rq_wr_ptr_reg;
    logic [RQ_PTR_W-1:0] rq_rd_ptr_reg;
    logic [RQ_CNT_W-1:0] rq_cnt_reg;
    logic                rq_pop;

    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && (rq_cnt_reg < RQ_CNT_W'(RQ_DEPTH));
    assign exec     = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (cmd_take) state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // extract old value from the fetched word
    assign sh      = {cur_reg.boff, 3'b000};
    assign m       = size_mask(cur_reg.size);
    assign old     = (rd_word_reg >> sh) & m;
    assign is_word = (cur_reg.size == 4'd4);
    assign a       = is_word ? sext32(old) : old;
    assign b       = is_word ? sext32(cur_reg.wdata) : cur_reg.wdata;
    assign lt_s    = $signed(a) < $signed(b);
    assign lt_u    = (a & m) < (b & m);

    always_comb
    begin
        case (cur_reg.op)
            AMO_ADD:  alu = a + b;
            AMO_XOR:  alu = a ^ b;
            AMO_OR:   alu = a | b;
            AMO_AND:  alu = a & b;
            AMO_MIN:  alu = lt_s ? a : b;
            AMO_MAX:  alu = lt_s ? b : a;
            AMO_MINU: alu = lt_u ? a : b;
            AMO_MAXU: alu = lt_u ? b : a;
            default:  alu = cur_reg.wdata;   // swap and unknown codes
        endcase
    end

    assign resv_hit = resv_valid_reg && (resv_addr_reg == cur_reg.addr);

    always_comb
    begin
        mem_we     = 1'b0;
        store_data = cur_reg.wdata;
        rdata      = '0;
        resv_set   = 1'b0;
        resv_clr   = 1'b0;
        if (exec && cur_reg.status == ST_OK)
        begin
            unique case (cur_reg.kind)
                KIND_READ:  rdata = old;
                KIND_WRITE: mem_we = 1'b1;
                KIND_AMO:
                begin
                    case (cur_reg.op)
                        AMO_LR:
                        begin
                            resv_set = 1'b1;
                            rdata    = a;
                        end
                        AMO_SC:
                        begin
                            resv_clr = 1'b1;
                            mem_we   = resv_hit;
                            rdata    = resv_hit ? 64'd0 : 64'd1;
                        end
                        default:
                        begin
                            mem_we     = 1'b1;
                            store_data = alu;
                            rdata      = a;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign mem_wdata  = (rd_word_reg & ~(m << sh)) | ((store_data & m) << sh);
    assign res.rdata  = rdata;
    assign res.status = cur_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            resv_valid_reg <= 1'b0;
            resv_addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (resv_set)
            begin
                resv_valid_reg <= 1'b1;
                resv_addr_reg  <= cur_reg.addr;
            end
            else if (resv_clr)
            begin
                resv_valid_reg <= 1'b0;
                resv_addr_reg  <= '0;
            end
        end
    end

    // ram port: read on take, write back in exec
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg     <= cmd;
            rd_word_reg <= mem_reg[cmd.idx];
        end
        if (mem_we)
            mem_reg[cur_reg.idx] <= mem_wdata;
    end

    // result queue
    assign empty  = (rq_cnt_reg == '0);
    assign rq_pop = pop && !empty;
    assign rsp    = rq_reg[rq_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_cnt_reg    <= '0;
        end
        else
        begin
            if (exec)
                rq_wr_ptr_reg <= (rq_wr_ptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ?
                                 '0 : rq_wr_ptr_reg + 1'b1;
            if (rq_pop)
                rq_rd_ptr_reg <= (rq_rd_ptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ?
                                 '0 : rq_rd_ptr_reg + 1'b1;
            if (exec && !rq_pop)
                rq_cnt_reg <= rq_cnt_reg + 1'b1;
            else if (!exec && rq_pop)
                rq_cnt_reg <= rq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
            rq_reg[rq_wr_ptr_reg] <= res;
    end

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overflow");

    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> (state_reg == S_EXEC) ##1 !empty)
        else $error("taken word did not reach exec or left no room for its result");

    a_no_fault_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> exec && (cur_reg.status == ST_OK) && (cur_reg.kind != KIND_READ))
        else $error("ram written by a faulting access or a read");

    a_sc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && cur_reg.status == ST_OK && cur_reg.kind == KIND_AMO &&
         cur_reg.op == AMO_SC) |=> !resv_valid_reg)
        else $error("sc left the reservation valid");

    a_lr_sets: assert property (@(posedge clk) disable iff (!rst_n)
        resv_set |=> resv_valid_reg && (resv_addr_reg == $past(cur_reg.addr)))
        else $error("lr did not set the reservation");

endmodule

// ----- tb/sv/rv64_memory_with_atomics_unit_tb.sv -----
// rv64_memory_with_atomics_unit_tb: self-checking bench for the memory unit with atomics
// drives access words and apb register writes, predicts every result word in a scoreboard
// depends on rv64mwa_pkg and rv64_memory_with_atomics_unit
`timescale 1ns / 1ps

module rv64_memory_with_atomics_unit_tb;
    import rv64mwa_pkg::*;

    // kind code the unit answers with an access fault
    localparam logic [1:0] KIND_NONE    = 2'd3;
    // an atomic code with no operation of its own, handled like swap
    localparam logic [4:0] AMO_UNUSED   = 5'h07;

    // ram words that the bench fills before any read: the low and the high end
    localparam int unsigned LOADED_LO   = 64;
    localparam int unsigned LOADED_HI   = 16;

    localparam int unsigned PHASE_ITEMS  = 320;
    localparam int unsigned RANDOM_TOTAL = 5 * PHASE_ITEMS;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned MAX_PRINTS   = 40;

    localparam logic [4:0] AMO_CODES [11] = '{AMO_ADD, AMO_SWAP, AMO_LR, AMO_SC, AMO_XOR,
        AMO_OR, AMO_AND, AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU};

    // expected-result store and the memory/reservation image behind it
    class memory_scoreboard;
        logic [63:0] ram_base_q;
        logic [63:0] device_base_q;
        bit [63:0]   ram_img [WORD_COUNT];
        logic [63:0] resv_addr;
        bit          resv_valid;
        out_t        pending_rsp[$];
        int unsigned checked;
        int unsigned errors;

        function new();
            ram_base_q    = RAM_BASE_RST;
            device_base_q = DEVICE_BASE_RST;
            resv_addr     = '0;
            resv_valid    = 1'b0;
            checked       = 0;
            errors        = 0;
        endfunction

        function void set_reg(logic idx, logic [63:0] val);
            if (idx == REG_RAM_BASE)
                ram_base_q = val;
            else
                device_base_q = val;
        endfunction

        function logic [63:0] byte_mask(int unsigned sz);
            if (sz >= 8)
                return '1;
            return (64'd1 << (sz * 8)) - 64'd1;
        endfunction

        function logic [63:0] sign_word(logic [63:0] v);
            return {{32{v[31]}}, v[31:0]};
        endfunction

        // range check without wrap; offset from ram_base on success
        function bit in_ram(logic [63:0] addr, int unsigned sz, output logic [63:0] off);
            off = addr - ram_base_q;
            if (addr < ram_base_q)
                return 1'b0;
            return off <= MEM_BYTES_64 - 64'(sz);
        endfunction

        function logic [63:0] load_bytes(logic [63:0] off, int unsigned sz);
            logic [63:0] idx;
            idx = off >> 3;
            if (idx >= WORD_COUNT)
                return '0;
            return (ram_img[idx] >> (off[2:0] * 8)) & byte_mask(sz);
        endfunction

        function void store_bytes(logic [63:0] off, int unsigned sz, logic [63:0] data);
            logic [63:0] idx;
            logic [63:0] m;
            idx = off >> 3;
            m   = byte_mask(sz);
            if (idx < WORD_COUNT)
                ram_img[idx] = (ram_img[idx] & ~(m << (off[2:0] * 8)))
                             | ((data & m) << (off[2:0] * 8));
        endfunction

        function bit loaded_word(logic [63:0] idx);
            return idx < LOADED_LO || (idx >= WORD_COUNT - LOADED_HI && idx < WORD_COUNT);
        endfunction

        function logic [63:0] pick_word_off();
            int unsigned r;
            r = $urandom_range(0, LOADED_LO + LOADED_HI - 1);
            if (r < LOADED_LO)
                return 64'(r) * 8;
            return 64'(WORD_COUNT - LOADED_HI + (r - LOADED_LO)) * 8;
        endfunction

        // moves any access that reaches the ram onto a word the bench has filled
        function in_t steer_to_loaded(in_t w);
            logic [63:0] off;
            bit          hits;
            hits = (w.kind == KIND_AMO)
                || ((w.kind == KIND_READ || w.kind == KIND_WRITE) && w.addr < device_base_q);
            if (hits && in_ram(w.addr, w.size_bytes, off) && !loaded_word(off >> 3))
                w.addr = ram_base_q + pick_word_off() + (off & 64'd7);
            return w;
        endfunction

        // result of one access word; updates the ram image and the reservation
        function out_t predict_access(in_t w);
            out_t        r;
            logic [63:0] off, old, a, b, res;
            int unsigned sz;
            logic [4:0]  op;
            bit          word;
            r.rdata  = '0;
            r.status = ST_OK;
            sz   = w.size_bytes;
            op   = w.amo_funct7[6:2];
            word = (sz == 4);
            case (w.kind)
                KIND_READ, KIND_WRITE:
                begin
                    // device region wins over the range check
                    if (w.addr >= device_base_q)
                        r.status = ST_DEVICE;
                    else if (!in_ram(w.addr, sz, off))
                        r.status = ST_FAULT;
                    else if (sz == 0 || sz > 8 || (sz & (sz - 1)) != 0
                             || (w.addr & 64'(sz - 1)) != 0)
                        r.status = ST_MISALIGN;
                    else if (w.kind == KIND_READ)
                        r.rdata = load_bytes(off, sz);
                    else
                        store_bytes(off, sz, w.wdata);
                end
                KIND_AMO:
                begin
                    if (!in_ram(w.addr, sz, off))
                        r.status = ST_FAULT;
                    else if ((sz != 4 && sz != 8) || (w.addr & 64'(sz - 1)) != 0)
                        r.status = ST_MISALIGN;
                    else
                    begin
                        old = load_bytes(off, sz);
                        a   = word ? sign_word(old) : old;
                        b   = word ? sign_word(w.wdata) : w.wdata;
                        if (op == AMO_LR)
                        begin
                            resv_addr  = w.addr;
                            resv_valid = 1'b1;
                            r.rdata    = a;
                        end
                        else if (op == AMO_SC)
                        begin
                            if (resv_valid && resv_addr == w.addr)
                                store_bytes(off, sz, w.wdata);
                            else
                                r.rdata = 64'd1;
                            resv_valid = 1'b0;
                            resv_addr  = '0;
                        end
                        else
                        begin
                            case (op)
                                AMO_ADD:  res = a + b;
                                AMO_XOR:  res = a ^ b;
                                AMO_OR:   res = a | b;
                                AMO_AND:  res = a & b;
                                AMO_MIN:  res = ($signed(a) < $signed(b)) ? a : b;
                                AMO_MAX:  res = ($signed(a) < $signed(b)) ? b : a;
                                AMO_MINU: res = ((a & byte_mask(sz)) < (b & byte_mask(sz))) ? a : b;
                                AMO_MAXU: res = ((a & byte_mask(sz)) < (b & byte_mask(sz))) ? b : a;
                                default:  res = w.wdata;
                            endcase
                            store_bytes(off, sz, res);
                            r.rdata = a;
                        end
                    end
                end
                default:
                    r.status = ST_FAULT;
            endcase
            return r;
        endfunction

        function void note_access(in_t w);
            pending_rsp.push_back(predict_access(w));
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        task report(string msg);
            errors++;
            // a broken unit would flood the log, so only the first ones are shown
            if (errors <= MAX_PRINTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(out_t got);
            out_t want;
            if (pending_rsp.size() == 0)
            begin
                report($sformatf("result word %h/%0d with nothing outstanding",
                                 got.rdata, got.status));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.rdata !== want.rdata)
                report($sformatf("word %0d rdata %h, want %h", checked, got.rdata, want.rdata));
            if (got.status !== want.status)
                report($sformatf("word %0d status %0d, want %0d", checked, got.status,
                                 want.status));
            checked++;
        endtask
    endclass

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                push    = 1'b0;
    logic                full;
    in_t                 req     = '0;
    logic                empty;
    logic                pop     = 1'b0;
    out_t                rsp;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [63:0]         pwdata  = '0;
    logic [63:0]         prdata;
    logic                pready;

    memory_scoreboard sb = new();

    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 76;
    int unsigned random_sent   = 0;
    int unsigned cycle_cnt     = 0;

    rv64_memory_with_atomics_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .req     (req),
        .empty   (empty),
        .pop     (pop),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // hard stop in case the unit hangs
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("rv64_memory_with_atomics_unit verification failed");
            $finish;
        end
    end

    // receiver: pop stalls at random according to the current idling mode
    always @(posedge clk)
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);

    // every result word taken at this edge is checked against the oldest prediction
    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_result(rsp);

    function automatic in_t mk(logic [1:0] kind, logic [63:0] addr, int unsigned sz,
                               logic [4:0] op, logic [63:0] data);
        in_t w;
        w.kind       = kind;
        w.addr       = addr;
        w.size_bytes = 4'(sz);
        // aq/rl bits are don't-care for the unit, so they toggle freely
        w.amo_funct7 = {op, 2'($urandom_range(0, 3))};
        w.wdata      = data;
        return w;
    endfunction

    // operands biased toward sign and width corners for min/max and add
    function automatic logic [63:0] gen_data();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'h0000_0000_8000_0000;
            3:       return 64'h0000_0000_7fff_ffff;
            4:       return 64'h8000_0000_0000_0000;
            5:       return {{32{r[31]}}, r};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [4:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r == 11)
            return 5'($urandom_range(0, 31));
        return AMO_CODES[r];
    endfunction

    // address on a filled word, rounded up to the access size
    function automatic logic [63:0] aligned_in_window(int unsigned sz);
        logic [63:0] a;
        a = sb.ram_base_q + sb.pick_word_off();
        return (a + 64'(sz) - 64'd1) & ~(64'(sz) - 64'd1);
    endfunction

    // well-formed access: legal size, aligned, on a filled word
    function automatic in_t gen_plain();
        int unsigned r, sz;
        logic [1:0]  kind;
        r    = $urandom_range(0, 99);
        kind = (r < 35) ? KIND_READ : ((r < 60) ? KIND_WRITE : KIND_AMO);
        if (kind == KIND_AMO)
            sz = $urandom_range(0, 1) ? 8 : 4;
        else
            sz = 1 << $urandom_range(0, 3);
        return sb.steer_to_loaded(mk(kind, aligned_in_window(sz), sz, pick_op(), gen_data()));
    endfunction

    // any field value: odd sizes, stray addresses, kind 3, boundary hits
    function automatic in_t gen_noise();
        in_t w;
        w.kind       = 2'($urandom_range(0, 3));
        w.size_bytes = 4'($urandom_range(0, 15));
        w.amo_funct7 = 7'($urandom_range(0, 127));
        w.wdata      = gen_data();
        case ($urandom_range(0, 5))
            0:       w.addr = {$urandom, $urandom};
            1:       w.addr = sb.ram_base_q - 64'($urandom_range(1, 16));
            2:       w.addr = sb.ram_base_q + MEM_BYTES_64 - 64'($urandom_range(0, 16));
            3:       w.addr = sb.ram_base_q + sb.pick_word_off() + 64'($urandom_range(0, 7));
            4:       w.addr = sb.device_base_q + 64'($urandom_range(0, 15)) - 64'd8;
            default: w.addr = '1;
        endcase
        return sb.steer_to_loaded(w);
    endfunction

    // present one word and hold it until the unit takes it
    task automatic push_word(input in_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req  <= w;
        do
            @(posedge clk);
        while (full);
        sb.note_access(w);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the register takes the value once pready is seen
    task automatic write_reg(input logic idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_SEL_BIT;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic reconfigure(input logic [63:0] rb, input logic [63:0] db);
        wait_drained();
        write_reg(REG_RAM_BASE, rb);
        write_reg(REG_DEVICE_BASE, db);
    endtask

    // idling modes: sender light/receiver heavy, then swapped, then none
    task automatic set_idle();
        if (random_sent < RANDOM_TOTAL / 3)
        begin
            send_idle_pct = 16;
            recv_idle_pct <= 76;
        end
        else if (random_sent < 2 * RANDOM_TOTAL / 3)
        begin
            send_idle_pct = 76;
            recv_idle_pct <= 16;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
        end
    endtask

    // mostly well-formed words and lr/sc pairs with random content, the rest noise
    task automatic run_random(input int unsigned n);
        int unsigned sent, k, sz, pick;
        bit          paused;
        logic [63:0] lr_at, sc_at;
        sent   = 0;
        paused = 1'b0;
        while (sent < n)
        begin
            set_idle();
            // halfway through, hold off until the unit has answered everything
            if (!paused && sent >= n / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                push_word(gen_plain());
                k = 1;
            end
            else if (pick < 70)
            begin
                // lr, a few unrelated words, then sc mostly to the reserved address
                sz    = $urandom_range(0, 1) ? 8 : 4;
                lr_at = aligned_in_window(sz);
                push_word(sb.steer_to_loaded(mk(KIND_AMO, lr_at, sz, AMO_LR, gen_data())));
                k = $urandom_range(0, 3);
                repeat (k) push_word(gen_plain());
                sc_at = ($urandom_range(0, 3) != 0) ? lr_at : aligned_in_window(sz);
                push_word(sb.steer_to_loaded(mk(KIND_AMO, sc_at, sz, AMO_SC, gen_data())));
                k += 2;
            end
            else
            begin
                push_word(gen_noise());
                k = 1;
            end
            sent        += k;
            random_sent += k;
        end
    endtask

    initial
    begin
        in_t         directed[$];
        logic [63:0] b;
        int unsigned idx;
        b = RAM_BASE_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both ends of the ram with full words so that no read sees undefined data
        for (int i = 0; i < LOADED_LO + LOADED_HI; i++)
        begin
            idx = (i < LOADED_LO) ? i : WORD_COUNT - LOADED_HI + (i - LOADED_LO);
            push_word(mk(KIND_WRITE, b + 64'(idx) * 8, 8, 5'($urandom_range(0, 31)),
                         gen_data()));
        end

        // directed words under the reset bases
        directed.push_back(mk(KIND_READ,  b,                     8,  AMO_ADD, '0));
        directed.push_back(mk(KIND_READ,  b + 1,                 1,  AMO_ADD, '0));
        directed.push_back(mk(KIND_WRITE, b + 3,                 1,  AMO_ADD, '1));
        directed.push_back(mk(KIND_READ,  b,                     4,  AMO_ADD, '0));
        directed.push_back(mk(KIND_READ,  b,                     0,  AMO_ADD, '0));
        directed.push_back(mk(KIND_READ,  b,                     3,  AMO_ADD, '0));
        directed.push_back(mk(KIND_READ,  b + 16,                15, AMO_ADD, '0));
        directed.push_back(mk(KIND_WRITE, b + 4,                 8,  AMO_ADD, '1));
        directed.push_back(mk(KIND_READ,  b - 1,                 1,  AMO_ADD, '0));
        directed.push_back(mk(KIND_READ,  b + MEM_BYTES_64 - 8,  8,  AMO_ADD, '0));
        directed.push_back(mk(KIND_WRITE, b + MEM_BYTES_64 - 4,  8,  AMO_ADD, '1));
        directed.push_back(mk(KIND_READ,  '1,                    1,  AMO_ADD, '0));
        directed.push_back(mk(KIND_NONE,  b,                     8,  AMO_ADD, '1));
        directed.push_back(mk(KIND_AMO,   b + 16, 8, AMO_SWAP, 64'h8000_0000_0000_0001));
        directed.push_back(mk(KIND_AMO,   b + 16, 8, AMO_ADD,  '1));
        directed.push_back(mk(KIND_AMO,   b + 20, 4, AMO_XOR,  64'h0000_0000_ffff_0000));
        directed.push_back(mk(KIND_AMO,   b + 24, 4, AMO_OR,   64'h0000_0000_8000_0000));
        directed.push_back(mk(KIND_AMO,   b + 24, 8, AMO_AND,  64'hf0f0_f0f0_0f0f_0f0f));
        directed.push_back(mk(KIND_AMO,   b + 32, 4, AMO_MIN,  64'h0000_0000_8000_0000));
        directed.push_back(mk(KIND_AMO,   b + 32, 4, AMO_MAX,  64'h0000_0000_7fff_ffff));
        directed.push_back(mk(KIND_AMO,   b + 40, 8, AMO_MINU, '1));
        directed.push_back(mk(KIND_AMO,   b + 40, 4, AMO_MAXU, 64'h0000_0000_8000_0001));
        directed.push_back(mk(KIND_AMO,   b + 48, 8, AMO_UNUSED, 64'h0123_4567_89ab_cdef));
        // sc with no reservation fails; lr then sc to the same word succeeds once
        directed.push_back(mk(KIND_AMO,   b + 48, 8, AMO_SC,   '1));
        directed.push_back(mk(KIND_AMO,   b + 56, 4, AMO_LR,   '0));
        directed.push_back(mk(KIND_AMO,   b + 56, 4, AMO_SC,   64'h0000_0000_dead_beef));
        directed.push_back(mk(KIND_AMO,   b + 64, 8, AMO_LR,   '0));
        directed.push_back(mk(KIND_AMO,   b + 72, 8, AMO_SC,   '1));
        // misaligned atomic, and an atomic at a device address takes the range check
        directed.push_back(mk(KIND_AMO,   b + 2,  4, AMO_ADD,  '1));
        directed.push_back(mk(KIND_AMO,   '1,     8, AMO_ADD,  '1));
        foreach (directed[i])
            push_word(directed[i]);

        run_random(PHASE_ITEMS);

        // ram at address zero, device region only at the very top
        reconfigure('0, '1);
        run_random(PHASE_ITEMS);

        // ram at the top of the address space, every read and write goes to the device
        reconfigure(64'hffff_ffff_ffff_ffff - MEM_BYTES_64 + 64'd1, '0);
        run_random(PHASE_ITEMS);

        // ram base off word alignment, device region starting inside the ram
        reconfigure(64'h0000_5a5a_0000_1233, 64'h0000_5a5a_0000_1333);
        run_random(PHASE_ITEMS);

        // reset ram base again, device region cutting off the high end of the ram
        reconfigure(RAM_BASE_RST, RAM_BASE_RST + 64'h200);
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("rv64_memory_with_atomics_unit verification clean");
        else
            $display("rv64_memory_with_atomics_unit verification failed");
        $finish;
    end

endmodule
